>>> design/assert_macros.svh
// assertion macros shared by the event queue rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

>>> design/sceq_pkg.sv
// types and constants of the sorted countdown event queue
// no dependencies; used by every module of the block
package sceq_pkg;

  localparam int TAG_W  = 16;
  localparam int STEP_W = 16;
  localparam int OVD_W  = 17;
  localparam int OCC_W  = 5;
  localparam int KIND_W = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd50;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [KIND_W-1:0] RK_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] RK_EXPIRED = 2'd1;
  localparam logic [KIND_W-1:0] RK_SUMMARY = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT,
    OP_SUB
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

>>> design/sceq_cell.sv
// one slot of the sorted queue: time and tag plus local compare and subtract
// depends on sceq_pkg
module sceq_cell #(
  parameter int TIME_BITS = 24
) (
  input  logic                        clk,
  input  sceq_pkg::cell_op_t          op,
  input  logic                        occupied,
  input  logic [TIME_BITS-1:0]        delay,
  input  logic [sceq_pkg::TAG_W-1:0]  new_tag,
  input  logic [sceq_pkg::STEP_W-1:0] step,
  input  logic [TIME_BITS-1:0]        left_time,
  input  logic [sceq_pkg::TAG_W-1:0]  left_tag,
  input  logic                        left_mark,
  input  logic [TIME_BITS-1:0]        right_time,
  input  logic [sceq_pkg::TAG_W-1:0]  right_tag,
  output logic [TIME_BITS-1:0]        time_q,
  output logic [sceq_pkg::TAG_W-1:0]  tag_q,
  output logic                        mark,
  output logic                        expired,
  output logic [sceq_pkg::OVD_W-1:0]  overdue
);
  import sceq_pkg::*;

  localparam int SW = (TIME_BITS > STEP_W) ? TIME_BITS + 1 : STEP_W + 1;

  logic [TIME_BITS-1:0] etime_r;
  logic [TAG_W-1:0]     etag_r;
  logic [SW-1:0]        diff;

  assign diff    = SW'(etime_r) - SW'(step);
  // borrow out of the wide subtract means time < step
  assign expired = occupied && diff[SW-1];
  // new item goes after every entry with time <= delay
  assign mark    = !occupied || (etime_r > delay);
  assign overdue = diff[OVD_W-1:0];
  assign time_q  = etime_r;
  assign tag_q   = etag_r;

  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT: begin
        if (mark && !left_mark) begin
          etime_r <= delay;
          etag_r  <= new_tag;
        end else if (mark) begin
          etime_r <= left_time;
          etag_r  <= left_tag;
        end
      end
      OP_SHIFT: begin
        etime_r <= right_time;
        etag_r  <= right_tag;
      end
      OP_SUB: begin
        etime_r <= diff[TIME_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/sceq_chain.sv
// row of queue cells with neighbor links, head taps and expired-count encoder
// depends on sceq_pkg and sceq_cell
module sceq_chain #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 24,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                        clk,
  input  sceq_pkg::cell_op_t          op,
  input  logic [CW-1:0]               count,
  input  logic [TIME_BITS-1:0]        delay,
  input  logic [sceq_pkg::TAG_W-1:0]  new_tag,
  input  logic [sceq_pkg::STEP_W-1:0] step,
  output logic [sceq_pkg::TAG_W-1:0]  head_tag,
  output logic [sceq_pkg::OVD_W-1:0]  head_overdue,
  output logic [CW-1:0]               gone
);
  import sceq_pkg::*;

  logic [TIME_BITS-1:0] c_time    [QUEUE_DEPTH];
  logic [TAG_W-1:0]     c_tag     [QUEUE_DEPTH];
  logic [OVD_W-1:0]     c_overdue [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_mark;
  logic [QUEUE_DEPTH-1:0] c_exp;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TIME_BITS-1:0] lt;
    logic [TAG_W-1:0]     lg;
    logic                 lm;
    logic [TIME_BITS-1:0] rt;
    logic [TAG_W-1:0]     rg;
    logic                 occ;

    if (i == 0) begin : g_first
      assign lt = '0;
      assign lg = '0;
      assign lm = 1'b0;
    end else begin : g_mid
      assign lt = c_time[i-1];
      assign lg = c_tag[i-1];
      assign lm = c_mark[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rt = c_time[i];
      assign rg = c_tag[i];
    end else begin : g_inner
      assign rt = c_time[i+1];
      assign rg = c_tag[i+1];
    end

    assign occ = (CW'(i) < count);

    sceq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk        (clk),
      .op         (op),
      .occupied   (occ),
      .delay      (delay),
      .new_tag    (new_tag),
      .step       (step),
      .left_time  (lt),
      .left_tag   (lg),
      .left_mark  (lm),
      .right_time (rt),
      .right_tag  (rg),
      .time_q     (c_time[i]),
      .tag_q      (c_tag[i]),
      .mark       (c_mark[i]),
      .expired    (c_exp[i]),
      .overdue    (c_overdue[i])
    );
  end

  assign head_tag     = c_tag[0];
  assign head_overdue = c_overdue[0];

  // expired flags form a run from the head; encode where the run ends
  always_comb begin
    logic edge_hit;
    gone = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == QUEUE_DEPTH - 1) edge_hit = c_exp[i];
      else edge_hit = c_exp[i] && !c_exp[i+1];
      if (edge_hit) gone = gone | CW'(i + 1);
    end
  end

endmodule

>>> design/sorted_countdown_event_queue_top.sv
// top level of the sorted countdown event queue
// depends on sceq_pkg, sceq_chain, sceq_cell and assert_macros.svh
//
// usage
//   in channel: in_tuser = action (0 insert, 1 tick), in_tdata = delay then
//   event_tag. an insert answers with one status item; a tick answers with one
//   item per expired entry (head first) and then a summary item with tlast.
//   out channel: out_tuser = result_kind, out_tdata carries dropped,
//   expired_tag, overdue_time and occupancy.
//   cfg channel: cfg_data sets tick_step, always ready; write only while idle.
// sequencing
//   one item is handled at a time. an insert result is loaded into the output
//   register from the insert state after acceptance; a tick passes through the
//   scan state and then the emit state, which loads expired entries from the
//   head of the cell row one per cycle while the output register can take them,
//   and then the summary. in_tready rises at the edge that loads the last result.
// reset
//   queue empties (count cleared), tick_step returns to 50, output goes idle.
// stalls
//   results sit in a single output register; while it is full and out_tready
//   is low the sequencer holds in its insert and emit states and the cell row keeps its contents.
module sorted_countdown_event_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // low to high: delay[TIME_BITS], event_tag[16], zero pad
  input  logic [((TIME_BITS+16+7)/8)*8-1:0]    in_tdata,
  // bit 0: action
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // low to high: dropped[1], expired_tag[16], overdue_time[17], occupancy[5], zero pad
  output logic [39:0]                          out_tdata,
  // bits 1:0: result_kind
  output logic [sceq_pkg::KIND_W-1:0]          out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sceq_pkg::STEP_W-1:0]          cfg_data
);
  import sceq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // sequencer and control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    left_r, left_nxt;     // expired items still to send
  logic [STEP_W-1:0] step_r;

  // captured item payload
  logic [TIME_BITS-1:0] delay_r;
  logic [TAG_W-1:0]     tag_r;

  // output register
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_drop_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [OVD_W-1:0]  out_ovd_r;
  logic [CW-1:0]     out_occ_r;
  logic              out_last_r;

  // next output item
  logic              load;
  logic [KIND_W-1:0] ld_kind;
  logic              ld_drop;
  logic [TAG_W-1:0]  ld_tag;
  logic [OVD_W-1:0]  ld_ovd;
  logic [CW-1:0]     ld_occ;
  logic              ld_last;

  cell_op_t          op;
  logic [TAG_W-1:0]  head_tag;
  logic [OVD_W-1:0]  head_overdue;
  logic [CW-1:0]     gone;
  logic              in_fire;
  logic              can_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  // output slot is free or being emptied this cycle
  assign can_load  = !out_valid_r || out_tready;

  sceq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .CW          (CW)
  ) u_chain (
    .clk          (clk),
    .op           (op),
    .count        (count_r),
    .delay        (delay_r),
    .new_tag      (tag_r),
    .step         (step_r),
    .head_tag     (head_tag),
    .head_overdue (head_overdue),
    .gone         (gone)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      left_r  <= '0;
      step_r  <= STEP_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      if (cfg_valid && cfg_ready) step_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      delay_r <= in_tdata[TIME_BITS-1:0];
      tag_r   <= in_tdata[TIME_BITS+TAG_W-1:TIME_BITS];
    end
  end

  // sequencer: next state, cell row command and output item
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    op        = OP_HOLD;
    load      = 1'b0;
    ld_kind   = RK_INSERT;
    ld_drop   = 1'b0;
    ld_tag    = '0;
    ld_ovd    = '0;
    ld_occ    = count_r;
    ld_last   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = (in_tuser == ACT_TICK) ? ST_SCAN : ST_INS;
      end
      ST_INS: begin
        if (can_load) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
          if (count_r == CW'(QUEUE_DEPTH)) begin
            ld_drop = 1'b1;
          end else begin
            op        = OP_INSERT;
            count_nxt = count_r + CW'(1);
            ld_occ    = count_r + CW'(1);
          end
        end
      end
      ST_SCAN: begin
        // final occupancy known up front; cells below count keep their data
        left_nxt  = gone;
        count_nxt = count_r - gone;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_load) begin
          load = 1'b1;
          if (left_r != '0) begin
            op       = OP_SHIFT;
            left_nxt = left_r - CW'(1);
            ld_kind  = RK_EXPIRED;
            ld_tag   = head_tag;
            ld_ovd   = head_overdue;
            ld_last  = 1'b0;
          end else begin
            op        = OP_SUB;
            ld_kind   = RK_SUMMARY;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= ld_kind;
      out_drop_r <= ld_drop;
      out_tag_r  <= ld_tag;
      out_ovd_r  <= ld_ovd;
      out_occ_r  <= ld_occ;
      out_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, OCC_W'(out_occ_r), out_ovd_r, out_tag_r, out_drop_r};

  `include "assert_macros.svh"

  // the queue never holds more than its depth
  `ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH))
  // one item at a time: after acceptance the input side is busy
  `ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready)
  // an expired entry always reports a negative remaining time
  `ASSERT_IMPL(a_expired_negative, out_tvalid && out_tuser == RK_EXPIRED, out_tdata[33])
  // status and summary items close their step
  `ASSERT_IMPL(a_closing_last, out_tvalid && out_tuser != RK_EXPIRED, out_tlast)

endmodule
